>>> design/shared_exclusive_lock_table_macros.svh
// shared assertion macros for the lock table
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_MACROS_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_MACROS_SVH
`define SELT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define SELT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> design/selt_pkg.sv
// ----------------------------------------------------------------------------
// selt_pkg
// constants and types shared by the lock table modules
// ----------------------------------------------------------------------------
package selt_pkg;
  localparam int NUM_TXNS_DEF   = 16;
  localparam int NUM_TABLES_DEF = 64;
  localparam logic [1:0] FUNC_ACQ = 2'd0;
  localparam logic [1:0] FUNC_REL = 2'd1;
  localparam logic [2:0] ST_GRANTED = 3'd0;
  localparam logic [2:0] ST_WAITING = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_NONE = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
endpackage

>>> design/shared_exclusive_lock_table.sv
// ----------------------------------------------------------------------------
// shared_exclusive_lock_table
// lock table with shared/exclusive locks and wait-for cycle detection
// ----------------------------------------------------------------------------
// acquire: reads the table entry, updates it, then presents the result
// release: scans every table, clears the txn's locks, then gives the result
// deadlock check: scans all tables into a wait-for graph, then prunes it
// one item at a time; next item taken the cycle after the result is accepted
// after reset a clearing pass writes every table entry before any item
module shared_exclusive_lock_table
  import selt_pkg::*;
#(
  parameter int NUM_TXNS   = NUM_TXNS_DEF,
  parameter int NUM_TABLES = NUM_TABLES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [3:0] in_txn_id,
  input  logic [5:0] in_table_index,
  input  logic       in_lock_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic       out_deadlock_found
);
  `include "shared_exclusive_lock_table_macros.svh"

  localparam int TW = $clog2(NUM_TABLES) > 0 ? $clog2(NUM_TABLES) : 1;
  localparam int XW = $clog2(NUM_TXNS + 1);
  localparam int RW = XW + 3 * NUM_TXNS;
  localparam int CW = $clog2(NUM_TABLES + NUM_TXNS + 2);

  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_ACQ = 3'd2, S_SCAN = 3'd3,
                         S_PRUNE = 3'd4, S_OUT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0] func_r;
  logic [3:0] txn_r;
  logic [TW-1:0] tab_r;
  logic tab_ok_r;
  logic mode_r;
  logic [NUM_TABLES-1:0] held_r [NUM_TXNS];
  logic [NUM_TXNS-1:0] adj_r [NUM_TXNS];
  logic [NUM_TXNS-1:0] alive_r;
  logic [2:0] st_r;
  logic dl_r;
  logic rvalid_r;
  logic [TW-1:0] rd_tab_r;

  logic we;
  logic [TW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  logic [XW-1:0] r_x;
  logic [NUM_TXNS-1:0] r_sh, r_ws, r_wx, tbit;

  selt_ram #(.WIDTH(RW), .DEPTH(NUM_TABLES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign {r_x, r_sh, r_ws, r_wx} = rdata;
  assign in_ready = (state_r == S_IDLE) && !out_valid;
  assign out_status = st_r;
  assign out_deadlock_found = dl_r;

  logic txn_ok, tab_ok;
  assign txn_ok = {1'b0, txn_r} < 5'(NUM_TXNS);
  assign tbit = txn_ok ? (NUM_TXNS'(1) << txn_r[$clog2(NUM_TXNS)-1:0]) : '0;

  logic [$clog2(NUM_TXNS)-1:0] txi;
  assign txi = txn_r[$clog2(NUM_TXNS)-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    we = 1'b0;
    waddr = rd_tab_r;
    wdata = rdata;
    raddr = TW'(cnt_r);
    case (state_r)
      S_CLR: begin
        we = 1'b1;
        waddr = TW'(cnt_r);
        wdata = {XW'(NUM_TXNS), {3 * NUM_TXNS{1'b0}}};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_TABLES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        raddr = in_table_index[TW-1:0];
        cnt_nxt = '0;
        if (in_valid && in_ready) begin
          case (in_func)
            FUNC_ACQ: state_nxt = S_ACQ;
            default: state_nxt = S_SCAN;
          endcase
        end
      end
      S_ACQ: begin
        // rdata valid once rvalid_r set
        if (rvalid_r) begin
          state_nxt = S_OUT;
          if (txn_ok && tab_ok) begin
            we = 1'b1;
            if (!mode_r) begin
              if (r_x >= XW'(NUM_TXNS) || r_x == XW'(txn_r))
                wdata = {r_x, r_sh | tbit, r_ws & ~tbit, r_wx};
              else
                wdata = {r_x, r_sh, r_ws | tbit, r_wx};
            end else begin
              if (r_x >= XW'(NUM_TXNS) && (r_sh == '0 || r_sh == tbit))
                wdata = {XW'(txn_r), r_sh, r_ws, r_wx & ~tbit};
              else
                wdata = {r_x, r_sh, r_ws, r_wx | tbit};
            end
          end
        end
        raddr = tab_r;
      end
      S_SCAN: begin
        if (cnt_r < CW'(NUM_TABLES)) cnt_nxt = cnt_r + 1'b1;
        if (rvalid_r && func_r == FUNC_REL) begin
          if (txn_ok && held_r[txi][rd_tab_r]) begin
            we = 1'b1;
            wdata = {(r_x == XW'(txn_r)) ? XW'(NUM_TXNS) : r_x, r_sh & ~tbit, r_ws, r_wx};
          end
        end
        if (rvalid_r && rd_tab_r == TW'(NUM_TABLES - 1)) begin
          cnt_nxt = '0;
          state_nxt = (func_r == FUNC_REL) ? S_OUT : S_PRUNE;
        end
      end
      S_PRUNE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_TXNS)) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign tab_ok = tab_ok_r;

  logic acq_grant;
  assign acq_grant = !mode_r ? (r_x >= XW'(NUM_TXNS) || r_x == XW'(txn_r))
                             : (r_x >= XW'(NUM_TXNS) && (r_sh == '0 || r_sh == tbit));

  logic any_held;
  always_comb begin
    any_held = 1'b0;
    if (txn_ok) any_held = held_r[txi] != '0;
  end

  // alive pruning: one full sweep per cycle over independent rows
  logic [NUM_TXNS-1:0] alive_nxt;
  always_comb begin
    for (int s = 0; s < NUM_TXNS; s++)
      alive_nxt[s] = alive_r[s] && ((adj_r[s] & alive_r) != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r <= '0;
      out_valid <= 1'b0;
      rvalid_r <= 1'b0;
      for (int t = 0; t < NUM_TXNS; t++) held_r[t] <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      rd_tab_r <= raddr;
      rvalid_r <= (state_r == S_ACQ) || (state_r == S_SCAN && cnt_r < CW'(NUM_TABLES));
      if (state_r == S_IDLE && in_valid && in_ready) begin
        func_r <= in_func;
        txn_r <= in_txn_id;
        tab_ok_r <= {1'b0, in_table_index} < 7'(NUM_TABLES);
        tab_r <= ({1'b0, in_table_index} < 7'(NUM_TABLES)) ? in_table_index[TW-1:0] : '0;
        mode_r <= in_lock_mode;
        for (int t = 0; t < NUM_TXNS; t++) adj_r[t] <= '0;
      end
      if (state_r == S_ACQ && rvalid_r) begin
        st_r <= (txn_ok && tab_ok && acq_grant) ? ST_GRANTED : ST_WAITING;
        dl_r <= 1'b0;
        if (txn_ok && tab_ok && acq_grant) held_r[txi][tab_r] <= 1'b1;
      end
      if (state_r == S_SCAN && rvalid_r && func_r != FUNC_REL) begin
        for (int w = 0; w < NUM_TXNS; w++) begin
          logic [NUM_TXNS-1:0] add;
          add = '0;
          if (r_ws[w] && r_x < XW'(NUM_TXNS) && r_x != XW'(w))
            add[r_x[$clog2(NUM_TXNS)-1:0]] = 1'b1;
          if (r_wx[w] && r_x < XW'(NUM_TXNS) && r_x != XW'(w))
            add[r_x[$clog2(NUM_TXNS)-1:0]] = 1'b1;
          if (r_wx[w] || (r_ws[w] && r_x < XW'(NUM_TXNS)))
            add = add | (r_sh & ~(NUM_TXNS'(1) << w));
          adj_r[w] <= adj_r[w] | add;
        end
      end
      if (state_r == S_SCAN && state_nxt == S_OUT) begin
        st_r <= any_held ? ST_RELEASED : ST_NONE;
        dl_r <= 1'b0;
        if (txn_ok) held_r[txi] <= '0;
      end
      if (state_r == S_SCAN && state_nxt == S_PRUNE) begin
        for (int s = 0; s < NUM_TXNS; s++) alive_r[s] <= 1'b1;
      end
      if (state_r == S_PRUNE) begin
        if (cnt_r == '0) begin
          for (int s = 0; s < NUM_TXNS; s++) alive_r[s] <= adj_r[s] != '0;
        end else begin
          alive_r <= alive_nxt;
        end
        if (state_nxt == S_OUT) begin
          st_r <= ST_CHECK;
          dl_r <= alive_nxt != '0;
        end
      end
      if (state_r != S_OUT && state_nxt == S_OUT) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  `SELT_ASSERT_IMPL(a_out_state, clk, rst_n, out_valid, state_r == S_OUT, "result outside output state")
  `SELT_ASSERT_NEXT(a_acc_busy, clk, rst_n, in_valid && in_ready, !in_ready, "second item accepted while busy")
  `SELT_ASSERT_IMPL(a_dl_check, clk, rst_n, out_valid && out_deadlock_found, out_status == ST_CHECK, "deadlock flag off a check")
endmodule

>>> design/selt_ram.sv
// ----------------------------------------------------------------------------
// selt_ram
// generic simple dual-port ram (one write, one read port) with registered read
// ----------------------------------------------------------------------------
module selt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> tb/shared_exclusive_lock_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock table checker
// watches both channels, keeps its own lock table, predicts the reply to
// each accepted item and compares it with the replies in order
// ----------------------------------------------------------------------------
module shared_exclusive_lock_table_checker
  import selt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [3:0] in_txn_id,
  input  logic [5:0] in_table_index,
  input  logic       in_lock_mode,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_status,
  input  logic       out_deadlock_found,
  output int         fail_count,
  output int         replies_owed
);
  localparam int NT = NUM_TXNS_DEF;
  localparam int NB = NUM_TABLES_DEF;

  typedef struct packed {
    logic [2:0] status;
    logic       deadlock;
  } reply_t;

  logic [4:0]    x_owner [NB];
  logic [NT-1:0] sharers [NB];
  logic [NT-1:0] wait_sh [NB];
  logic [NT-1:0] wait_ex [NB];
  logic [NB-1:0] tables_of [NT];
  reply_t        owed_replies[$];

  function automatic logic wait_cycle();
    logic [NT-1:0] edges [NT];
    logic [NT-1:0] live;
    logic          changed;
    live = '0;
    for (int w = 0; w < NT; w++) edges[w] = '0;
    for (int t = 0; t < NB; t++) begin
      for (int w = 0; w < NT; w++) begin
        for (int p = 0; p < 2; p++) begin
          if (p == 1 ? wait_ex[t][w] : wait_sh[t][w]) begin
            if (x_owner[t] < NT && x_owner[t] != w) edges[w][x_owner[t][3:0]] = 1'b1;
            if (p == 1 || x_owner[t] < NT) begin
              edges[w] |= sharers[t] & ~(NT'(1) << w);
            end
          end
        end
      end
    end
    for (int s = 0; s < NT; s++) live[s] = |edges[s];
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int s = 0; s < NT; s++) begin
        if (live[s] && (edges[s] & live) == '0) begin
          live[s] = 1'b0;
          changed = 1'b1;
        end
      end
    end
    return |live;
  endfunction

  function automatic reply_t lock_step(logic [1:0] f, logic [3:0] tx, logic [5:0] tb,
                                       logic md);
    reply_t r;
    r = '{status: ST_WAITING, deadlock: 1'b0};
    if (f == FUNC_ACQ) begin
      if (md == 1'b0) begin
        if (x_owner[tb] >= NT || x_owner[tb] == tx) begin
          wait_sh[tb][tx] = 1'b0;
          sharers[tb][tx] = 1'b1;
          tables_of[tx][tb] = 1'b1;
          r.status = ST_GRANTED;
        end else begin
          wait_sh[tb][tx] = 1'b1;
        end
      end else begin
        if (x_owner[tb] >= NT && (sharers[tb] == '0 || sharers[tb] == (NT'(1) << tx))) begin
          wait_ex[tb][tx] = 1'b0;
          x_owner[tb] = {1'b0, tx};
          tables_of[tx][tb] = 1'b1;
          r.status = ST_GRANTED;
        end else begin
          wait_ex[tb][tx] = 1'b1;
        end
      end
    end else if (f == FUNC_REL) begin
      r.status = ST_NONE;
      if (tables_of[tx] != '0) begin
        for (int t = 0; t < NB; t++) begin
          if (tables_of[tx][t]) begin
            sharers[t][tx] = 1'b0;
            if (x_owner[t] == tx) x_owner[t] = 5'(NT);
          end
        end
        tables_of[tx] = '0;
        r.status = ST_RELEASED;
      end
    end else begin
      r.status = ST_CHECK;
      r.deadlock = wait_cycle();
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t e;
    int     errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      replies_owed <= 0;
      owed_replies.delete();
      for (int t = 0; t < NB; t++) begin
        x_owner[t] = 5'(NT);
        sharers[t] = '0;
        wait_sh[t] = '0;
        wait_ex[t] = '0;
      end
      for (int x = 0; x < NT; x++) tables_of[x] = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          $error("reply with none outstanding: status %0d", out_status);
          errs = errs + 1;
        end else begin
          e = owed_replies.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            errs = errs + 1;
          end
          if (out_deadlock_found !== e.deadlock) begin
            $error("deadlock_found: expected %0d, got %0d", e.deadlock, out_deadlock_found);
            errs = errs + 1;
          end
        end
      end
      if (in_valid && in_ready)
        owed_replies.insert(owed_replies.size(),
                            lock_step(in_func, in_txn_id, in_table_index, in_lock_mode));
      fail_count <= fail_count + errs;
      replies_owed <= owed_replies.size();
    end
  end
endmodule

>>> tb/shared_exclusive_lock_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock table testbench
// directed lock scenarios including a deadlock, then random acquire,
// release, check and spare-code traffic over a few transactions and tables
// ----------------------------------------------------------------------------
module shared_exclusive_lock_table_test;
  import selt_pkg::*;

  localparam logic [1:0] FUNC_CHK = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_func;
  logic [3:0] in_txn_id;
  logic [5:0] in_table_index;
  logic       in_lock_mode;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_status;
  logic       out_deadlock_found;
  int         fail_count;
  int         replies_owed;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         idle_cycles;

  shared_exclusive_lock_table dut (.*);
  shared_exclusive_lock_table_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] f, logic [3:0] tx, logic [5:0] tb, logic md);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_txn_id <= tx;
    in_table_index <= tb;
    in_lock_mode <= md;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random();
    int k;
    logic [3:0] tx;
    logic [5:0] tb;
    k = $urandom_range(99);
    tx = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(3));
    tb = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(3) * 21);
    if (k < 70) send_item(FUNC_ACQ, tx, tb, 1'($urandom));
    else if (k < 85) send_item(FUNC_REL, tx, tb, 1'($urandom));
    else send_item(k < 95 ? FUNC_CHK : FUNC_SPARE, tx, 6'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_ACQ;
    in_txn_id = '0;
    in_table_index = '0;
    in_lock_mode = 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 49;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_item(FUNC_REL, 4'd0, 6'd0, 1'b0);
    send_item(FUNC_CHK, 4'd0, 6'd0, 1'b0);
    send_item(FUNC_ACQ, 4'd0, 6'd0, 1'b1);
    send_item(FUNC_ACQ, 4'd0, 6'd0, 1'b1);
    send_item(FUNC_ACQ, 4'd0, 6'd0, 1'b0);
    send_item(FUNC_ACQ, 4'd15, 6'd63, 1'b0);
    send_item(FUNC_ACQ, 4'd15, 6'd63, 1'b1);
    send_item(FUNC_ACQ, 4'd15, 6'd0, 1'b0);
    send_item(FUNC_ACQ, 4'd0, 6'd63, 1'b1);
    send_item(FUNC_CHK, 4'd0, 6'd0, 1'b0);
    send_item(FUNC_SPARE, 4'd15, 6'd63, 1'b1);
    send_item(FUNC_REL, 4'd15, 6'd63, 1'b0);
    send_item(FUNC_CHK, 4'd0, 6'd0, 1'b0);
    send_item(FUNC_ACQ, 4'd10, 6'd42, 1'b0);
    send_item(FUNC_ACQ, 4'd5, 6'd42, 1'b1);
    send_item(FUNC_REL, 4'd10, 6'd0, 1'b0);
    send_item(FUNC_ACQ, 4'd5, 6'd42, 1'b1);
    send_item(FUNC_REL, 4'd5, 6'd0, 1'b0);
    send_item(FUNC_REL, 4'd0, 6'd0, 1'b0);
    drain();

    for (int i = 0; i < 700; i++) begin
      if (i == 240) begin
        send_idle_pct = 49;
        recv_idle_pct = 9;
      end
      if (i == 480) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 350) drain();
      send_random();
    end
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
